### hw/rtl/sdq_pkg.sv
// Shared types and codes for the sorted delay queue.
package sdq_pkg;

	localparam int unsigned TASK_W   = 8;
	localparam int unsigned KEY_W    = 31;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned TDATA_W  = 40;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TASK_W-1:0] tid;
	} sdq_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_PLACE,
		ST_REM_DATA,
		ST_RESULT
	} sdq_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic rd_top;
		logic shift;
		logic place;
		logic pop;
		logic set_full;
		logic set_empty;
		logic emit;
	} sdq_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic empty;
		logic full;
		logic key_le;
		logic idx_one;
		logic out_free;
	} sdq_stat_t;

endpackage

### hw/rtl/sdq_datapath.sv
// Datapath of the sorted delay queue: entry memory, fill count, result and output registers.
module sdq_datapath #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sdq_pkg::sdq_cmd_t            cmd,
	output sdq_pkg::sdq_stat_t           stat,
	input  logic [sdq_pkg::TASK_W-1:0]   in_task_id,
	input  logic [sdq_pkg::KEY_W-1:0]    in_delay_key,
	input  logic                         m_tready,
	output logic                         m_tvalid,
	output logic [sdq_pkg::STATUS_W-1:0] out_status,
	output sdq_pkg::sdq_entry_t          out_entry
);
	import sdq_pkg::*;

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	sdq_entry_t mem_q [CAPACITY];
	sdq_entry_t rdata_q;
	sdq_entry_t item_q;
	sdq_entry_t res_entry_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic out_valid_q;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	sdq_entry_t    wr_data;
	logic [CW-1:0] top_idx;
	logic [CW-1:0] next_rd_idx;

	// Address the top entry on a request, the entry two below the hole while shifting
	assign top_idx     = count_q - CW'(1);
	assign next_rd_idx = idx_q - CW'(2);
	assign rd_en   = cmd.rd_top | (cmd.shift & ~stat.idx_one);
	assign rd_addr = cmd.rd_top ? top_idx[AW-1:0] : next_rd_idx[AW-1:0];
	assign wr_en   = cmd.shift | cmd.place;
	assign wr_addr = idx_q[AW-1:0];
	assign wr_data = cmd.place ? item_q : rdata_q;

	// Entry memory: one read and one write port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Capture the request and walk the hole down
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q.tid <= in_task_id;
			item_q.key <= in_delay_key;
			idx_q      <= count_q;
		end else if (cmd.shift) begin
			idx_q <= idx_q - CW'(1);
		end
	end

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.place) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Hold the pending result
	always_ff @(posedge clk) begin
		if (cmd.place) begin
			res_status_q <= STATUS_DONE;
			res_entry_q  <= '0;
		end else if (cmd.pop) begin
			res_status_q <= STATUS_DONE;
			res_entry_q  <= rdata_q;
		end else if (cmd.set_full) begin
			res_status_q <= STATUS_FULL;
			res_entry_q  <= '0;
		end else if (cmd.set_empty) begin
			res_status_q <= STATUS_EMPTY;
			res_entry_q  <= '0;
		end
	end

	// Output register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status <= res_status_q;
			out_entry  <= res_entry_q;
		end
	end

	assign m_tvalid = out_valid_q;

	// Status towards the controller
	assign stat.empty    = (count_q == '0);
	assign stat.full     = (count_q == CW'(CAPACITY));
	assign stat.key_le   = (rdata_q.key <= item_q.key);
	assign stat.idx_one  = (idx_q == CW'(1));
	assign stat.out_free = ~out_valid_q | m_tready;

endmodule

### hw/rtl/sdq_ctrl.sv
// Controller state machine of the sorted delay queue.
module sdq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic               req_cmd,
	input  sdq_pkg::sdq_stat_t stat,
	output sdq_pkg::sdq_cmd_t  cmd
);
	import sdq_pkg::*;

	sdq_state_t state_q;
	sdq_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (req_cmd == CMD_INSERT) begin
						if (stat.full) begin
							cmd.set_full = 1'b1;
							state_d      = ST_RESULT;
						end else if (stat.empty) begin
							state_d = ST_PLACE;
						end else begin
							cmd.rd_top = 1'b1;
							state_d    = ST_SHIFT;
						end
					end else begin
						if (stat.empty) begin
							cmd.set_empty = 1'b1;
							state_d       = ST_RESULT;
						end else begin
							cmd.rd_top = 1'b1;
							state_d    = ST_REM_DATA;
						end
					end
				end
			end
			// Move entries with a key not above the new one up by one
			ST_SHIFT: begin
				if (stat.key_le) begin
					cmd.shift = 1'b1;
					if (stat.idx_one) begin
						state_d = ST_PLACE;
					end
				end else begin
					cmd.place = 1'b1;
					state_d   = ST_RESULT;
				end
			end
			ST_PLACE: begin
				cmd.place = 1'b1;
				state_d   = ST_RESULT;
			end
			ST_REM_DATA: begin
				cmd.pop = 1'b1;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/sorted_delay_queue_core.sv
// Top level of the sorted delay queue: controller and datapath.
//
// Requests enter on the s_* stream: s_tuser carries the operation (insert or
// remove), s_tdata the task id and delay key of an insert. Each request gives
// exactly one result on the m_* stream: a status in m_tuser and, for a
// successful remove, the entry with the smallest delay key (oldest first among
// equal keys) in m_tdata, zeros otherwise.
// Entries live in a single-port-read, single-port-write memory kept in
// descending key order. A remove reads the top entry, pops it and then emits
// its result. An insert first moves every stored entry whose key is not above
// the new key up by one slot, then places the new entry and emits the result;
// the shift loop moves one entry per cycle through the memory port. Refused
// requests (full or empty) go straight to their result.
// One request is worked on at a time; s_tready is high whenever the engine is
// idle, also while an earlier result still waits in the output register.
// If the receiver stalls, the finished result waits in the engine until the
// output register frees, and no new request is taken meanwhile.
// Reset clears the fill count and the output valid; memory contents are not
// cleared and are never read before being written.
module sorted_delay_queue_core #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [sdq_pkg::TDATA_W-1:0]   s_tdata,  // task_id[7:0], delay_key[38:8], pad
	input  logic                          s_tuser,  // cmd[0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sdq_pkg::TDATA_W-1:0]   m_tdata,  // out_task_id[7:0], out_delay_key[38:8], pad
	output logic [sdq_pkg::STATUS_W-1:0]  m_tuser   // status[1:0]
);
	import sdq_pkg::*;

	sdq_cmd_t   cmd;
	sdq_stat_t  stat;
	sdq_entry_t out_entry;

	sdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.req_cmd  (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	sdq_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_task_id   (s_tdata[TASK_W-1:0]),
		.in_delay_key (s_tdata[TASK_W+KEY_W-1:TASK_W]),
		.m_tready     (m_tready),
		.m_tvalid     (m_tvalid),
		.out_status   (m_tuser),
		.out_entry    (out_entry)
	);

	// Pack the result entry, zero pad to whole bytes
	assign m_tdata = {{(TDATA_W - TASK_W - KEY_W){1'b0}}, out_entry.key, out_entry.tid};

endmodule

### sim/tb_sorted_delay_queue_core.sv
// Self-checking testbench for the sorted delay queue core.
module tb_sorted_delay_queue_core;

	import sdq_pkg::*;

	localparam int unsigned CAPACITY     = 64;
	localparam int unsigned PAD_W        = TDATA_W - TASK_W - KEY_W;
	localparam int unsigned RANDOM_REQS  = 1350;
	localparam int unsigned DRAIN_CYCLES = 3 + CAPACITY + 30;
	localparam int unsigned HOLDOFF_LEN  = 400;
	localparam int unsigned LIMIT_CYCLES = 800000;

	// Receiver back-pressure patterns
	typedef enum logic [1:0] {
		RX_FREE,
		RX_HALF,
		RX_SPARSE,
		RX_RHYTHM
	} rx_mode_t;

	typedef struct {
		logic              cmd;
		logic [TASK_W-1:0] tid;
		logic [KEY_W-1:0]  key;
		bit                settle; // wait for every result before offering
	} queue_req_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [TASK_W-1:0]   tid;
		logic [KEY_W-1:0]    key;
	} queue_result_t;

	logic                clk;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata  = '0;
	logic                s_tuser  = CMD_INSERT;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic [STATUS_W-1:0] m_tuser;

	// Shadow copy of the sorted store, descending key order, smallest at top
	logic [KEY_W-1:0]  shadow_key [CAPACITY];
	logic [TASK_W-1:0] shadow_tid [CAPACITY];
	int unsigned       shadow_fill = 0;

	queue_req_t    req_backlog[$];
	queue_result_t due_results[$];
	queue_req_t    cur_req;

	int unsigned total_reqs  = 0;
	int unsigned n_accepted  = 0;
	int unsigned n_results   = 0;
	int unsigned n_mismatch  = 0;
	int unsigned n_ins_done  = 0;
	int unsigned n_ins_full  = 0;
	int unsigned n_rem_done  = 0;
	int unsigned n_rem_empty = 0;
	int unsigned peak_fill   = 0;

	sorted_delay_queue_core #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Apply one request to the shadow store and return the result it must give
	function automatic queue_result_t update_shadow_queue(queue_req_t r);
		queue_result_t res;
		int unsigned   pos;
		res.status = STATUS_DONE;
		res.tid    = '0;
		res.key    = '0;
		if (r.cmd == CMD_INSERT) begin
			if (shadow_fill >= CAPACITY) begin
				res.status = STATUS_FULL;
				n_ins_full++;
				return res;
			end
			// skip every entry with a strictly larger key, then open a slot
			pos = 0;
			while (pos < shadow_fill && shadow_key[pos] > r.key)
				pos++;
			for (int unsigned i = shadow_fill; i > pos; i--) begin
				shadow_key[i] = shadow_key[i-1];
				shadow_tid[i] = shadow_tid[i-1];
			end
			shadow_key[pos] = r.key;
			shadow_tid[pos] = r.tid;
			shadow_fill++;
			n_ins_done++;
			if (shadow_fill > peak_fill)
				peak_fill = shadow_fill;
		end else begin
			if (shadow_fill == 0) begin
				res.status = STATUS_EMPTY;
				n_rem_empty++;
				return res;
			end
			shadow_fill--;
			res.tid = shadow_tid[shadow_fill];
			res.key = shadow_key[shadow_fill];
			n_rem_done++;
		end
		return res;
	endfunction

	// Keys cluster on a few small values so equal keys are frequent
	function automatic logic [KEY_W-1:0] pick_key();
		int unsigned pick = $urandom_range(0, 9);
		logic [31:0] raw  = $urandom();
		if (pick < 4)
			return KEY_W'($urandom_range(0, 15));
		if (pick == 4)
			return '0;
		if (pick == 5)
			return '1;
		return raw[KEY_W-1:0];
	endfunction

	task automatic add_req(logic cmd, logic [TASK_W-1:0] tid, logic [KEY_W-1:0] key,
			bit settle);
		queue_req_t r;
		r.cmd    = cmd;
		r.tid    = tid;
		r.key    = key;
		r.settle = settle;
		req_backlog.push_back(r);
	endtask

	// Sender: bursts of requests with random gaps, predicting on acceptance
	int unsigned burst_left = 1;
	int unsigned gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		int unsigned outstanding;
		bit          offer;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= CMD_INSERT;
		end else begin
			outstanding = n_accepted - n_results;
			if (s_tvalid && s_tready) begin
				due_results.push_back(update_shadow_queue(cur_req));
				n_accepted  <= n_accepted + 1;
				outstanding++;
			end
			offer = 1'b0;
			if (s_tvalid && !s_tready) begin
				// hold the request until it is taken
				offer = 1'b1;
			end else if (req_backlog.size() != 0) begin
				if (req_backlog[0].settle && outstanding != 0) begin
					// pause until every result is back
				end else if (gap_left != 0) begin
					gap_left--;
				end else begin
					req_backlog[0].settle = 1'b0;
					cur_req = req_backlog.pop_front();
					s_tdata <= {{PAD_W{1'b0}}, cur_req.key, cur_req.tid};
					s_tuser <= cur_req.cmd;
					offer   = 1'b1;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
			s_tvalid <= offer;
		end
	end

	// Receiver: changing stall patterns and two long hold-offs
	rx_mode_t    rx_mode      = RX_FREE;
	int unsigned rx_mode_left = 0;
	int unsigned rx_tick      = 0;
	int unsigned hold_left    = 0;
	int unsigned holds_done   = 0;

	always @(posedge clk or negedge arst_n) begin
		int unsigned hold_at;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			rx_tick++;
			hold_at = (holds_done == 0) ? 300 : 1000;
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (holds_done < 2 && n_accepted >= hold_at) begin
				hold_left = HOLDOFF_LEN;
				holds_done++;
				m_tready <= 1'b0;
			end else begin
				if (rx_mode_left == 0) begin
					rx_mode      = rx_mode_t'($urandom_range(0, 3));
					rx_mode_left = $urandom_range(20, 200);
				end
				rx_mode_left--;
				case (rx_mode)
					RX_FREE:   m_tready <= 1'b1;
					RX_HALF:   m_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
					default:   m_tready <= ((rx_tick % 7) < 4);
				endcase
			end
		end
	end

	// Checker: compare each result with the oldest outstanding prediction
	always @(posedge clk) begin
		queue_result_t want;
		logic [TASK_W-1:0] got_tid;
		logic [KEY_W-1:0]  got_key;
		if (arst_n && m_tvalid && m_tready) begin
			got_tid = m_tdata[TASK_W-1:0];
			got_key = m_tdata[TASK_W+KEY_W-1:TASK_W];
			n_results <= n_results + 1;
			if (due_results.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("[%0t] unexpected result: status %0d task %0d key %0d",
						$time, m_tuser, got_tid, got_key);
			end else begin
				want = due_results.pop_front();
				if (m_tuser !== want.status || got_tid !== want.tid || got_key !== want.key) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display({"[%0t] mismatch: status %0d/%0d task %0d/%0d",
							" key %0d/%0d (exp/got)"},
							$time, want.status, m_tuser, want.tid, got_tid,
							want.key, got_key);
				end
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int unsigned phase_len;
		int unsigned insert_pct;
		int unsigned n_directed;

		// remove from an empty store, with junk on the ignored fields
		add_req(CMD_REMOVE, 8'hFF, '1, 1'b0);
		// extremes of both fields and a run of equal keys
		add_req(CMD_INSERT, 8'h00, '0, 1'b0);
		add_req(CMD_INSERT, 8'hFF, '1, 1'b0);
		add_req(CMD_INSERT, 8'h5A, 31'd100, 1'b0);
		add_req(CMD_INSERT, 8'hA5, 31'd100, 1'b0);
		add_req(CMD_INSERT, 8'h3C, 31'd100, 1'b0);
		add_req(CMD_INSERT, 8'h01, '1, 1'b0);
		add_req(CMD_INSERT, 8'hC3, 31'h2AAA_AAAA, 1'b0);
		add_req(CMD_INSERT, 8'h96, 31'h5555_5555, 1'b0);
		// pop everything back: smallest key first, oldest first among equals
		for (int i = 0; i < 9; i++)
			add_req(CMD_REMOVE, 8'($urandom_range(0, 255)), pick_key(), 1'b0);
		add_req(CMD_REMOVE, 8'h00, '0, 1'b0);
		n_directed = req_backlog.size();

		// fill beyond capacity, then drain beyond empty
		for (int i = 0; i < CAPACITY + 8; i++)
			add_req(CMD_INSERT, 8'($urandom_range(0, 255)), pick_key(), i == 0);
		for (int i = 0; i < CAPACITY + 8; i++)
			add_req(CMD_REMOVE, 8'($urandom_range(0, 255)), pick_key(), 1'b0);

		// phases biased towards filling, draining or balance
		while (req_backlog.size() < n_directed + RANDOM_REQS) begin
			phase_len = $urandom_range(20, 120);
			case ($urandom_range(0, 4))
				0:       insert_pct = 85;
				1:       insert_pct = 15;
				2:       insert_pct = 65;
				3:       insert_pct = 35;
				default: insert_pct = 50;
			endcase
			for (int j = 0; j < phase_len; j++)
				add_req(($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE,
					8'($urandom_range(0, 255)), pick_key(),
					j == 0 && $urandom_range(0, 3) == 0);
		end
		total_reqs = req_backlog.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		wait (n_accepted == total_reqs);
		wait (n_results == n_accepted);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display({"Covered %0d requests: %0d inserts (%0d refused full),",
			" %0d removes (%0d refused empty)"},
			total_reqs, n_ins_done, n_ins_full, n_rem_done, n_rem_empty);
		$display("Peak fill %0d of %0d, %0d results checked, %0d mismatches",
			peak_fill, CAPACITY, n_results, n_mismatch);
		if (n_mismatch == 0 && due_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#(12 * LIMIT_CYCLES);
		$display("Timeout: %0d of %0d requests accepted, %0d results outstanding",
			n_accepted, total_reqs, due_results.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule

### files.f
hw/rtl/sdq_pkg.sv
hw/rtl/sdq_datapath.sv
hw/rtl/sdq_ctrl.sv
hw/rtl/sorted_delay_queue_core.sv
sim/tb_sorted_delay_queue_core.sv
